### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the touch packet queue.
// Included by each module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TPAQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define TPAQ_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/tpaq_pkg.sv
// Types, codes and constants of the touch packet assembler and sample queue.
// No dependencies; used by every file of the block but tpaq_ram and assert_macros.svh.
package tpaq_pkg;

  localparam int COORD_W         = 10;
  localparam int TIME_W          = 48;
  localparam int DROP_W          = 16;
  localparam int LEVEL_W         = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]         SYNC_BYTE = 8'hFF;
  localparam logic [COORD_W-1:0] PENUP_X   = 10'd1019;
  localparam logic [COORD_W-1:0] PENUP_Y   = 10'd0;

  // Item commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_MID     = 3'd0,
    ST_DISCARD = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_FIRST   = 3'd3,
    ST_DROPPED = 3'd4,
    ST_READ_OK = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  // Byte position within a packet.
  typedef enum logic [4:0] {
    POS_SYNC = 5'b00001,
    POS_XLO  = 5'b00010,
    POS_XHI  = 5'b00100,
    POS_YLO  = 5'b01000,
    POS_YHI  = 5'b10000
  } pos_e;

  // One queued sample, as stored in the queue memory.
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic               pressed;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } touch_smp_t;

  // Outcome of one serial byte, handed from the assembler to the queue.
  typedef struct packed {
    status_e    status;
    logic       push;
    touch_smp_t sample;
  } asm_evt_t;

endpackage

### hdl/tpaq_in_if.sv
// Input channel of the touch packet queue: command, serial byte and time.
// Depends on tpaq_pkg for the field widths.
interface tpaq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [7:0]                 data_byte;
  logic [tpaq_pkg::TIME_W-1:0] timestamp;

  modport source (output valid, output command, output data_byte, output timestamp,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input timestamp,
                  output ready);
endinterface

### hdl/tpaq_out_if.sv
// Result channel of the touch packet queue: status, sample read and counters.
// Depends on tpaq_pkg for the field widths.
interface tpaq_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [tpaq_pkg::COORD_W-1:0] sample_x;
  logic [tpaq_pkg::COORD_W-1:0] sample_y;
  logic                         sample_pressed;
  logic [tpaq_pkg::TIME_W-1:0]  sample_time;
  logic [tpaq_pkg::DROP_W-1:0]  drop_total;
  logic [tpaq_pkg::LEVEL_W-1:0] queue_level;

  modport source (output valid, output status, output sample_x, output sample_y,
                  output sample_pressed, output sample_time, output drop_total,
                  output queue_level, input ready);
  modport sink   (input valid, input status, input sample_x, input sample_y,
                  input sample_pressed, input sample_time, input drop_total,
                  input queue_level, output ready);
endinterface

### hdl/tpaq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tpaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tpaq_assembler.sv
// Packet assembler: byte position, packet under assembly and the held sample.
// Depends on tpaq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpaq_assembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_acc_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [tpaq_pkg::TIME_W-1:0] timestamp_i,
  output tpaq_pkg::asm_evt_t          evt_o
);

  tpaq_pkg::pos_e                     pos_d, pos_q;
  logic                               have_prev_d, have_prev_q;
  logic [tpaq_pkg::COORD_W-1:0]       cur_x_d, cur_x_q;
  logic [tpaq_pkg::COORD_W-1:0]       cur_y_d, cur_y_q;
  logic [tpaq_pkg::TIME_W-1:0]        cur_time_d, cur_time_q;
  tpaq_pkg::touch_smp_t               prev_d, prev_q;
  logic [tpaq_pkg::COORD_W-1:0]       y_full;
  logic                               penup;

  // The Y coordinate completes with the last byte of a packet.
  assign y_full = {data_byte_i, cur_y_q[1:0]};
  assign penup  = (cur_x_q == tpaq_pkg::PENUP_X) && (y_full == tpaq_pkg::PENUP_Y);

  // Byte decoding and the hold-back of one sample.
  always_comb begin
    pos_d         = pos_q;
    have_prev_d   = have_prev_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    cur_time_d    = cur_time_q;
    prev_d        = prev_q;
    evt_o.status  = tpaq_pkg::ST_MID;
    evt_o.push    = 1'b0;
    evt_o.sample  = prev_q;
    unique case (pos_q)
      tpaq_pkg::POS_SYNC: begin
        if (data_byte_i != tpaq_pkg::SYNC_BYTE) begin
          evt_o.status = tpaq_pkg::ST_DISCARD;
        end else begin
          cur_time_d = timestamp_i;
          cur_x_d    = '0;
          cur_y_d    = '0;
          pos_d      = tpaq_pkg::POS_XLO;
        end
      end
      tpaq_pkg::POS_XLO: begin
        cur_x_d = {8'd0, data_byte_i[7:6]};
        pos_d   = tpaq_pkg::POS_XHI;
      end
      tpaq_pkg::POS_XHI: begin
        cur_x_d = {data_byte_i, cur_x_q[1:0]};
        pos_d   = tpaq_pkg::POS_YLO;
      end
      tpaq_pkg::POS_YLO: begin
        cur_y_d = {8'd0, data_byte_i[7:6]};
        pos_d   = tpaq_pkg::POS_YHI;
      end
      tpaq_pkg::POS_YHI: begin
        cur_y_d = y_full;
        pos_d   = tpaq_pkg::POS_SYNC;
        if (!have_prev_q) begin
          // The very first packet is only held, always as pen down.
          prev_d       = '{stamp: cur_time_q, pressed: 1'b1, y: y_full, x: cur_x_q};
          have_prev_d  = 1'b1;
          evt_o.status = tpaq_pkg::ST_FIRST;
        end else begin
          // A pen-up packet releases the held sample but keeps it held.
          evt_o.status         = tpaq_pkg::ST_QUEUED;
          evt_o.push           = 1'b1;
          evt_o.sample.pressed = prev_q.pressed & ~penup;
          if (penup) begin
            prev_d.pressed = 1'b0;
          end else begin
            prev_d = '{stamp: cur_time_q, pressed: 1'b1, y: y_full, x: cur_x_q};
          end
        end
      end
      default: begin
        pos_d = tpaq_pkg::POS_SYNC;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= tpaq_pkg::POS_SYNC;
      have_prev_q <= 1'b0;
    end else if (byte_acc_i) begin
      pos_q       <= pos_d;
      have_prev_q <= have_prev_d;
    end
  end

  // Packet and held sample payload.
  always_ff @(posedge clk_i) begin
    if (byte_acc_i) begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      cur_time_q <= cur_time_d;
      prev_q     <= prev_d;
    end
  end

  `TPAQ_NEVER(a_push_without_held, clk_i, rst_ni, evt_o.push && !have_prev_q,
              "push requested with no held sample")
  `TPAQ_ASSERT(a_first_sets_held, clk_i, rst_ni,
               (byte_acc_i && evt_o.status == tpaq_pkg::ST_FIRST) |=>
               (have_prev_q && pos_q == tpaq_pkg::POS_SYNC),
               "first packet did not leave a held sample")
  `TPAQ_ASSERT(a_pos_onehot, clk_i, rst_ni, $onehot(pos_q),
               "byte position is not one-hot")

endmodule

### hdl/tpaq_queue.sv
// Sample queue: ring pointers, drop counter, queue memory and the result stages.
// Depends on tpaq_pkg, tpaq_ram and assert_macros.svh.
`include "assert_macros.svh"

module tpaq_queue #(
  parameter int QUEUE_DEPTH = tpaq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         command_i,
  output logic                         in_ready_o,
  input  tpaq_pkg::asm_evt_t           evt_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output tpaq_pkg::touch_smp_t         sample_o,
  output logic [tpaq_pkg::DROP_W-1:0]  drop_total_o,
  output logic [tpaq_pkg::LEVEL_W-1:0] queue_level_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int SMP_W = $bits(tpaq_pkg::touch_smp_t);

  logic                        accept, adv;
  logic [PTR_W-1:0]            wp_d, wp_q, rp_d, rp_q, wp_next, rp_next;
  logic                        empty, full;
  logic [tpaq_pkg::DROP_W-1:0] drop_d, drop_q;
  logic [PTR_W:0]              level;
  logic                        ram_we, ram_re;
  logic [SMP_W-1:0]            ram_rdata;
  tpaq_pkg::status_e           status_s0;

  logic                         s1_v_q;
  tpaq_pkg::status_e            s1_status_q;
  logic [tpaq_pkg::DROP_W-1:0]  s1_drop_q;
  logic [tpaq_pkg::LEVEL_W-1:0] s1_level_q;

  logic                         out_v_q;
  tpaq_pkg::status_e            out_status_q;
  tpaq_pkg::touch_smp_t         out_sample_q;
  logic [tpaq_pkg::DROP_W-1:0]  out_drop_q;
  logic [tpaq_pkg::LEVEL_W-1:0] out_level_q;

  // Stage one may be refilled whenever the output register can take its item.
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // Ring pointers.
  assign wp_next = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign empty   = (wp_q == rp_q);
  assign full    = (wp_next == rp_q);

  // Queue decision for the item being accepted. A read and a write never come
  // from the same item, and a read only reaches entries written in earlier
  // cycles, so the memory needs no forwarding path.
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    drop_d    = drop_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    status_s0 = evt_i.status;
    if (command_i == tpaq_pkg::CMD_READ) begin
      if (empty) begin
        status_s0 = tpaq_pkg::ST_EMPTY;
      end else begin
        status_s0 = tpaq_pkg::ST_READ_OK;
        ram_re    = accept;
        rp_d      = rp_next;
      end
    end else if (evt_i.push) begin
      if (full) begin
        status_s0 = tpaq_pkg::ST_DROPPED;
        if (drop_q != '1) begin
          drop_d = drop_q + 1'b1;
        end
      end else begin
        ram_we = accept;
        wp_d   = wp_next;
      end
    end
  end

  // Entries waiting once this item is done.
  always_comb begin
    if (wp_d >= rp_d) begin
      level = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      level = {1'b0, wp_d} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, rp_d};
    end
  end

  tpaq_ram #(
    .WIDTH (SMP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (evt_i.sample),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Pointer and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      drop_q <= '0;
    end else if (accept) begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      drop_q <= drop_d;
    end
  end

  // Stage one waits for the memory read; the output register holds the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_s0;
      s1_drop_q   <= drop_d;
      s1_level_q  <= level[tpaq_pkg::LEVEL_W-1:0];
    end
    if (adv && s1_v_q) begin
      out_status_q <= s1_status_q;
      out_drop_q   <= s1_drop_q;
      out_level_q  <= s1_level_q;
      if (s1_status_q == tpaq_pkg::ST_READ_OK) begin
        out_sample_q <= tpaq_pkg::touch_smp_t'(ram_rdata);
      end else begin
        out_sample_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = out_status_q;
  assign sample_o      = out_sample_q;
  assign drop_total_o  = out_drop_q;
  assign queue_level_o = out_level_q;

  `TPAQ_NEVER(a_write_when_full, clk_i, rst_ni, ram_we && full,
              "queue memory written while the ring is full")
  `TPAQ_ASSERT(a_drop_monotonic, clk_i, rst_ni, $past(drop_q) <= drop_q,
               "drop counter went backwards")
  `TPAQ_ASSERT(a_out_held, clk_i, rst_ni, (out_v_q && !out_ready_i) |=> out_v_q,
               "stalled result was withdrawn")

endmodule

### hdl/touch_packet_assembler_queue.sv
// Top level of the touch packet assembler with its sample queue.
// Depends on tpaq_pkg, tpaq_in_if, tpaq_out_if, tpaq_assembler and tpaq_queue.
//
//   channel | direction | carries
//   in_i    | sink      | command, data_byte, timestamp
//   out_o   | source    | status, sample fields, drop_total, queue_level
//
// One item is taken every cycle while results are drained; each gives one result.
// A result passes through stage one, which waits for the queue memory read, and
// then through the output register.
// Reset clears the byte position, held-sample flag, ring pointers and drop count;
// the queue memory is not cleared, as only written entries are ever read.
// A stalled output holds its result; input stalls only once both stages are full.
module touch_packet_assembler_queue #(
  parameter int QUEUE_DEPTH = tpaq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpaq_in_if.sink    in_i,
  tpaq_out_if.source out_o
);

  logic                 in_acc, byte_acc;
  tpaq_pkg::asm_evt_t   evt;
  tpaq_pkg::touch_smp_t sample;

  // Serial bytes advance the assembler only when taken.
  assign in_acc   = in_i.valid && in_i.ready;
  assign byte_acc = in_acc && (in_i.command == tpaq_pkg::CMD_BYTE);

  tpaq_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_acc_i  (byte_acc),
    .data_byte_i (in_i.data_byte),
    .timestamp_i (in_i.timestamp),
    .evt_o       (evt)
  );

  tpaq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .command_i     (in_i.command),
    .in_ready_o    (in_i.ready),
    .evt_i         (evt),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .sample_o      (sample),
    .drop_total_o  (out_o.drop_total),
    .queue_level_o (out_o.queue_level)
  );

  // Unpack the sample read onto the result fields.
  assign out_o.sample_x       = sample.x;
  assign out_o.sample_y       = sample.y;
  assign out_o.sample_pressed = sample.pressed;
  assign out_o.sample_time    = sample.stamp;

endmodule

### tb/sv/touch_packet_assembler_queue_test.sv
// Self-checking testbench of touch_packet_assembler_queue: directed, random, back-pressure
// and full-ring runs, all checked against a cycle-free model of the block.
// Depends on tpaq_pkg, tpaq_in_if, tpaq_out_if and the RTL of the block.
`timescale 1ns / 1ps

module touch_packet_assembler_queue_test;

  localparam int QUEUE_DEPTH  = tpaq_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 730;
  localparam int FULL_PACKETS = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REP_W        = tpaq_pkg::TIME_W;

  // Expected outcome of one item.
  typedef struct {
    tpaq_pkg::status_e                status;
    tpaq_pkg::touch_smp_t             sample;
    logic [tpaq_pkg::DROP_W-1:0]      drops;
    logic [tpaq_pkg::LEVEL_W-1:0]     level;
  } touch_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tpaq_in_if  touch_in ();
  tpaq_out_if touch_out ();

  touch_packet_assembler_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (touch_in),
    .out_o (touch_out)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model state: packet being assembled, held sample, sample ring and drop count.
  tpaq_pkg::pos_e               asm_pos = tpaq_pkg::POS_SYNC;
  logic [tpaq_pkg::COORD_W-1:0] asm_x = '0;
  logic [tpaq_pkg::COORD_W-1:0] asm_y = '0;
  logic [tpaq_pkg::TIME_W-1:0]  asm_time = '0;
  logic                         held_valid = 1'b0;
  tpaq_pkg::touch_smp_t         held = '0;
  tpaq_pkg::touch_smp_t         ring [QUEUE_DEPTH];
  int unsigned                  wr_ptr = 0;
  int unsigned                  rd_ptr = 0;
  logic [tpaq_pkg::DROP_W-1:0]  drops = '0;

  touch_result_t awaited_results [$];
  int            mismatches = 0;
  int            sent_items = 0;
  int            burst_left = 0;
  logic          sender_steady = 1'b0;
  logic          receiver_always = 1'b0;
  logic          hold_req = 1'b0;
  int            hold_left = 0;
  int            rx_mode = 0;
  int            rx_window = 0;
  int            idle_cycles = 0;

  function automatic logic [tpaq_pkg::TIME_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[tpaq_pkg::TIME_W-1:0];
  endfunction

  // Stores the held sample in the ring, or counts it as dropped when the ring is full.
  function automatic tpaq_pkg::status_e store_held();
    if ((wr_ptr + 1) % QUEUE_DEPTH == rd_ptr) begin
      if (drops != '1) drops++;
      return tpaq_pkg::ST_DROPPED;
    end
    ring[wr_ptr] = held;
    wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
    return tpaq_pkg::ST_QUEUED;
  endfunction

  // Works out the result of one accepted item and advances the model state.
  function automatic touch_result_t predict_touch(input logic cmd, input logic [7:0] b,
                                                  input logic [tpaq_pkg::TIME_W-1:0] ts);
    touch_result_t r;
    logic          is_penup;
    int unsigned   lvl;
    r.status = tpaq_pkg::ST_MID;
    r.sample = '0;
    if (cmd == tpaq_pkg::CMD_READ) begin
      if (rd_ptr == wr_ptr) begin
        r.status = tpaq_pkg::ST_EMPTY;
      end else begin
        r.sample = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        r.status = tpaq_pkg::ST_READ_OK;
      end
    end else begin
      case (asm_pos)
        tpaq_pkg::POS_SYNC: begin
          if (b != tpaq_pkg::SYNC_BYTE) begin
            r.status = tpaq_pkg::ST_DISCARD;
          end else begin
            asm_time = ts;
            asm_x = '0;
            asm_y = '0;
            asm_pos = tpaq_pkg::POS_XLO;
          end
        end
        tpaq_pkg::POS_XLO: begin
          asm_x = {8'd0, b[7:6]};
          asm_pos = tpaq_pkg::POS_XHI;
        end
        tpaq_pkg::POS_XHI: begin
          asm_x = {b, asm_x[1:0]};
          asm_pos = tpaq_pkg::POS_YLO;
        end
        tpaq_pkg::POS_YLO: begin
          asm_y = {8'd0, b[7:6]};
          asm_pos = tpaq_pkg::POS_YHI;
        end
        default: begin
          asm_y = {b, asm_y[1:0]};
          asm_pos = tpaq_pkg::POS_SYNC;
          if (!held_valid) begin
            // The first packet is only held, pen-up code or not.
            held = '{stamp: asm_time, pressed: 1'b1, y: asm_y, x: asm_x};
            held_valid = 1'b1;
            r.status = tpaq_pkg::ST_FIRST;
          end else begin
            is_penup = (asm_x == tpaq_pkg::PENUP_X) && (asm_y == tpaq_pkg::PENUP_Y);
            if (is_penup) held.pressed = 1'b0;
            r.status = store_held();
            if (!is_penup) held = '{stamp: asm_time, pressed: 1'b1, y: asm_y, x: asm_x};
          end
        end
      endcase
    end
    r.drops = drops;
    lvl = (wr_ptr + QUEUE_DEPTH - rd_ptr) % QUEUE_DEPTH;
    r.level = lvl[tpaq_pkg::LEVEL_W-1:0];
    return r;
  endfunction

  // Offers one item in the sender's burst pattern and records its expected result.
  task automatic send_item(input logic cmd, input logic [7:0] b,
                           input logic [tpaq_pkg::TIME_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        touch_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    touch_in.valid     <= 1'b1;
    touch_in.command   <= cmd;
    touch_in.data_byte <= b;
    touch_in.timestamp <= ts;
    @(posedge clk_i);
    while (!touch_in.ready) @(posedge clk_i);
    awaited_results.push_back(predict_touch(cmd, b, ts));
    sent_items++;
  endtask

  task automatic send_read();
    send_item(tpaq_pkg::CMD_READ, 8'($urandom), rand_stamp());
  endtask

  // Sends a whole packet; a read is slipped in after byte read_after when it is 0 to 4.
  task automatic send_packet(input logic [tpaq_pkg::COORD_W-1:0] x,
                             input logic [tpaq_pkg::COORD_W-1:0] y,
                             input logic [tpaq_pkg::TIME_W-1:0] stamp, input int read_after);
    logic [7:0] bytes [5];
    bytes[0] = tpaq_pkg::SYNC_BYTE;
    bytes[1] = {x[1:0], 6'($urandom)};
    bytes[2] = x[9:2];
    bytes[3] = {y[1:0], 6'($urandom)};
    bytes[4] = y[9:2];
    for (int k = 0; k < 5; k++) begin
      send_item(tpaq_pkg::CMD_BYTE, bytes[k], (k == 0) ? stamp : rand_stamp());
      if (k == read_after) send_read();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [REP_W-1:0] got,
                                 input logic [REP_W-1:0] want);
    mismatches++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Reset-time picture: empty reads, stray bytes, a pen-up first packet, a read during a
  // packet, extreme coordinates and stamps, then a pen-up that releases the held sample.
  task automatic test_directed();
    send_read();
    send_item(tpaq_pkg::CMD_BYTE, 8'h00, '0);
    send_item(tpaq_pkg::CMD_BYTE, 8'hFE, '1);
    send_packet(tpaq_pkg::PENUP_X, tpaq_pkg::PENUP_Y, '1, -1);
    send_packet(10'h3FF, 10'h3FF, '0, 1);
    send_packet(tpaq_pkg::PENUP_X, tpaq_pkg::PENUP_Y, rand_stamp(), -1);
    repeat (3) send_read();
  endtask

  // Mostly well-formed packets with random content, mixed with reads, noise and
  // packets cut short so that later bytes land mid-packet.
  task automatic test_random();
    int stop_at;
    int pick;
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        case ($urandom_range(0, 9))
          0, 1:    send_packet(tpaq_pkg::PENUP_X, tpaq_pkg::PENUP_Y, rand_stamp(), -1);
          2:       send_packet(tpaq_pkg::PENUP_X, 10'd1, rand_stamp(), -1);
          3:       send_packet(10'd1018, tpaq_pkg::PENUP_Y, rand_stamp(),
                               $urandom_range(0, 4));
          default: send_packet(10'($urandom), 10'($urandom), rand_stamp(),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : -1);
        endcase
      end else if (pick < 76) begin
        send_read();
      end else if (pick < 88) begin
        send_item(tpaq_pkg::CMD_BYTE, 8'($urandom), rand_stamp());
      end else begin
        send_item(tpaq_pkg::CMD_BYTE, tpaq_pkg::SYNC_BYTE, rand_stamp());
        repeat ($urandom_range(1, 3))
          send_item(tpaq_pkg::CMD_BYTE, 8'($urandom), rand_stamp());
      end
    end
  endtask

  // The receiver holds off for a long stretch while packets keep coming, so both
  // pipeline stages fill and the input stalls.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_req = 1'b1;
    repeat (6) send_packet(10'($urandom), 10'($urandom), rand_stamp(), 2);
    repeat (4) send_read();
    sender_steady = 1'b0;
  endtask

  // Keeps the ring full while packets keep arriving, so that samples are dropped.
  task automatic test_ring_full();
    sender_steady = 1'b1;
    receiver_always = 1'b1;
    repeat (FULL_PACKETS) send_packet(10'($urandom), 10'($urandom), rand_stamp(), -1);
    repeat (QUEUE_DEPTH) send_read();
    sender_steady = 1'b0;
    receiver_always = 1'b0;
  endtask

  // Result side: long holds on request, otherwise random stall windows of varying density.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      touch_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      touch_out.ready <= 1'b0;
    end else begin
      if (rx_window == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_window <= $urandom_range(16, 96);
      end else begin
        rx_window <= rx_window - 1;
      end
      touch_out.ready <= receiver_always || rx_mode == 0 || $urandom_range(0, 3) >= rx_mode;
    end
  end

  // Compares each accepted result with the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    touch_result_t want;
    if (rst_ni && touch_out.valid && touch_out.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected, status",
                        REP_W'(touch_out.status), '0);
      end else begin
        want = awaited_results.pop_front();
        if (touch_out.status !== want.status)
          report_mismatch("status", REP_W'(touch_out.status), REP_W'(want.status));
        if (touch_out.sample_x !== want.sample.x)
          report_mismatch("sample_x", REP_W'(touch_out.sample_x), REP_W'(want.sample.x));
        if (touch_out.sample_y !== want.sample.y)
          report_mismatch("sample_y", REP_W'(touch_out.sample_y), REP_W'(want.sample.y));
        if (touch_out.sample_pressed !== want.sample.pressed)
          report_mismatch("sample_pressed", REP_W'(touch_out.sample_pressed),
                          REP_W'(want.sample.pressed));
        if (touch_out.sample_time !== want.sample.stamp)
          report_mismatch("sample_time", touch_out.sample_time, want.sample.stamp);
        if (touch_out.drop_total !== want.drops)
          report_mismatch("drop_total", REP_W'(touch_out.drop_total), REP_W'(want.drops));
        if (touch_out.queue_level !== want.level)
          report_mismatch("queue_level", REP_W'(touch_out.queue_level), REP_W'(want.level));
      end
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((touch_in.valid && touch_in.ready) || (touch_out.valid && touch_out.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("touch_packet_assembler_queue test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    touch_in.valid = 1'b0;
    touch_in.command = tpaq_pkg::CMD_BYTE;
    touch_in.data_byte = '0;
    touch_in.timestamp = '0;
    touch_out.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();
    test_ring_full();

    // Drain what is still in flight, then allow for the two-stage pipeline.
    touch_in.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("touch_packet_assembler_queue test passed");
    else
      $display("touch_packet_assembler_queue test failed");
    $finish;
  end

endmodule
